// ----- src/fuzzy_word_matcher_unit_assert.svh -----
// Assertion macros for the fuzzy word matcher.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef FUZZY_WORD_MATCHER_UNIT_ASSERT_SVH
`define FUZZY_WORD_MATCHER_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define FWM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define FWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/fwm_pkg.sv -----
// Shared types, codes and helpers for the fuzzy word matcher.
// No dependencies; used by fwm_cell and fuzzy_word_matcher_unit.
package fwm_pkg;

	localparam int WORD_W           = 64;
	localparam int LEN_IN_W         = 4;
	localparam int CFG_IDX_W        = 4;
	localparam int DEF_MAX_WORD_LEN = 8;
	localparam int DEF_NUM_VARIANTS = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WORD    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEN     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANT_A_WORD = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANT_A_LEN  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANT_B_WORD = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANT_B_LEN  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANT_COUNT  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT     = 4'd7;

	localparam logic [3:0] MAX_DIST_RESET = 4'd2;

	// Match kinds
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_EXACT  = 2'd1;
	localparam logic [1:0] KIND_APPROX = 2'd2;

	// Row token passed from cell to cell
	typedef struct packed {
		logic       vld;
		logic       last;
		logic [7:0] chr;
	} link_t;

	// Saturate a length field at the supported maximum
	function automatic logic [3:0] clamp_len(input logic [3:0] v, input logic [3:0] cap);
		return (v > cap) ? cap : v;
	endfunction

endpackage

// ----- src/fwm_cell.sv -----
// One column cell of the edit-distance array: holds the previous row value
// for each reference lane and passes the row token on. Uses fwm_pkg.
module fwm_cell #(
	parameter int NREF   = 3,
	parameter int DIST_W = 4,
	parameter int COL    = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           init,
	input  logic [NREF-1:0][7:0]           ref_chr,
	input  fwm_pkg::link_t                 link_i,
	input  logic [NREF-1:0][DIST_W-1:0]    left_i,
	input  logic [NREF-1:0][DIST_W-1:0]    diag_i,
	output fwm_pkg::link_t                 link_o,
	output logic [NREF-1:0][DIST_W-1:0]    left_o,
	output logic [NREF-1:0][DIST_W-1:0]    diag_o
);

	localparam logic [DIST_W-1:0] COL_D = DIST_W'(COL);

	logic [NREF-1:0][DIST_W-1:0] up_q;
	logic [NREF-1:0][DIST_W-1:0] d;
	logic                        vld_q;
	logic                        last_q;
	logic [7:0]                  chr_q;

	// Cell recurrence: min of substitute, delete and insert
	always_comb begin
		logic [DIST_W:0] sub;
		logic [DIST_W:0] del;
		logic [DIST_W:0] ins;
		logic [DIST_W:0] best;
		for (int l = 0; l < NREF; l++) begin
			sub  = {1'b0, diag_i[l]} + ((link_i.chr != ref_chr[l]) ? (DIST_W+1)'(1) : '0);
			del  = {1'b0, up_q[l]} + (DIST_W+1)'(1);
			ins  = {1'b0, left_i[l]} + (DIST_W+1)'(1);
			best = sub;
			if (del < best) best = del;
			if (ins < best) best = ins;
			d[l] = best[DIST_W-1:0];
		end
	end

	// Token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= link_i.vld;
		end
	end

	// Row values and token payload
	always_ff @(posedge clk) begin
		if (init) begin
			for (int l = 0; l < NREF; l++) up_q[l] <= COL_D;
		end else if (link_i.vld) begin
			up_q   <= d;
			left_o <= d;
			diag_o <= up_q;
			last_q <= link_i.last;
			chr_q  <= link_i.chr;
		end
	end

	assign link_o.vld  = vld_q;
	assign link_o.last = last_q;
	assign link_o.chr  = chr_q;

endmodule

// ----- src/fuzzy_word_matcher_unit.sv -----
// Fuzzy word matcher top level: config registers, exact compare, control
// and the chain of fwm_cell columns. Uses fwm_pkg and the assert header.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects a
//   register (0..7), cfg_data carries the value. cfg_ready is always high;
//   writes beyond index 7 are dropped. Write only while busy is low.
//   Command: a transaction is accepted at an edge with start high and busy
//   low; candidate_word/candidate_len are sampled there.
//   Result: done is high for one cycle with match_kind valid, in state
//   S_DONE after the S_RUN phase; busy stays high through S_DONE, so a
//   new word is taken only once the previous result is out. S_RUN spans
//   the wavefront: candidate bytes enter one row per cycle and each row
//   crosses the L cells one cell per cycle, L = min(MAX_WORD_LEN, 8); all
//   references (target and variants) are evaluated in lanes in parallel.
//   Reset: configuration registers return to their reset values (distance
//   limit = 2, all else 0), block idle. The result consumer cannot stall
//   the block; each result is shown exactly once.
module fuzzy_word_matcher_unit #(
	parameter int MAX_WORD_LEN = fwm_pkg::DEF_MAX_WORD_LEN,
	parameter int NUM_VARIANTS = fwm_pkg::DEF_NUM_VARIANTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [fwm_pkg::WORD_W-1:0]        candidate_word,
	input  logic [fwm_pkg::LEN_IN_W-1:0]      candidate_len,
	output logic                              done,
	output logic [1:0]                        match_kind,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fwm_pkg::WORD_W-1:0]        cfg_data
);

	`include "fuzzy_word_matcher_unit_assert.svh"

	localparam int LEN_CAP = (MAX_WORD_LEN < 8) ? MAX_WORD_LEN : 8;
	localparam int VAR_CAP = (NUM_VARIANTS < 2) ? NUM_VARIANTS : 2;
	localparam int NREF    = 1 + VAR_CAP;
	localparam int LEN_W   = $clog2(LEN_CAP + 1);
	localparam int DIST_W  = LEN_W;
	localparam int ROW_W   = $clog2(LEN_CAP + 2);
	localparam int CAND_W  = 8 * LEN_CAP;
	localparam int CNT_W   = $clog2(2 * LEN_CAP);
	localparam int LATENCY = 2 * LEN_CAP + 1;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(2 * LEN_CAP - 1);
	localparam logic [3:0]       CAP4     = 4'(LEN_CAP);
	localparam logic [1:0]       VCAP2    = 2'(VAR_CAP);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	// Configuration registers
	logic [fwm_pkg::WORD_W-1:0] target_word_q;
	logic [fwm_pkg::WORD_W-1:0] variant_a_word_q;
	logic [fwm_pkg::WORD_W-1:0] variant_b_word_q;
	logic [LEN_W-1:0]           target_len_q;
	logic [LEN_W-1:0]           variant_a_len_q;
	logic [LEN_W-1:0]           variant_b_len_q;
	logic [1:0]                 variant_count_q;
	logic [3:0]                 dist_limit_q;

	// Control and per-item state
	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROW_W-1:0]  row_q;
	logic [LEN_W-1:0]  xlen_q;
	logic [CAND_W-1:0] cand_q;
	logic              exact_q;
	logic [NREF-1:0]   elig_q;
	logic [NREF-1:0]   hit_q;

	logic                        accept;
	logic                        feed;
	logic [LEN_W-1:0]            in_len;
	logic [1:0]                  nv;
	logic [fwm_pkg::WORD_W-1:0]  ref_word [NREF];
	logic [LEN_W-1:0]            ref_len  [NREF];
	logic [NREF-1:0]             lane_on;
	logic [NREF-1:0]             exact_lane;
	logic [NREF-1:0]             elig_lane;
	logic [NREF-1:0]             cap_en;
	logic [NREF-1:0][DIST_W-1:0] cap_d;
	logic [LEN_CAP-1:0]          last_vec;

	fwm_pkg::link_t              lnk    [LEN_CAP+1];
	logic [NREF-1:0][DIST_W-1:0] left_v [LEN_CAP+1];
	logic [NREF-1:0][DIST_W-1:0] diag_v [LEN_CAP+1];

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign in_len    = LEN_W'(fwm_pkg::clamp_len(candidate_len, CAP4));
	assign nv        = (variant_count_q > VCAP2) ? VCAP2 : variant_count_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_word_q    <= '0;
			target_len_q     <= '0;
			variant_a_word_q <= '0;
			variant_a_len_q  <= '0;
			variant_b_word_q <= '0;
			variant_b_len_q  <= '0;
			variant_count_q  <= '0;
			dist_limit_q     <= fwm_pkg::MAX_DIST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fwm_pkg::REG_TARGET_WORD: begin
					target_word_q <= cfg_data;
				end
				fwm_pkg::REG_TARGET_LEN: begin
					target_len_q <= LEN_W'(fwm_pkg::clamp_len(cfg_data[3:0], CAP4));
				end
				fwm_pkg::REG_VARIANT_A_WORD: begin
					variant_a_word_q <= cfg_data;
				end
				fwm_pkg::REG_VARIANT_A_LEN: begin
					variant_a_len_q <= LEN_W'(fwm_pkg::clamp_len(cfg_data[3:0], CAP4));
				end
				fwm_pkg::REG_VARIANT_B_WORD: begin
					variant_b_word_q <= cfg_data;
				end
				fwm_pkg::REG_VARIANT_B_LEN: begin
					variant_b_len_q <= LEN_W'(fwm_pkg::clamp_len(cfg_data[3:0], CAP4));
				end
				fwm_pkg::REG_VARIANT_COUNT: begin
					variant_count_q <= cfg_data[1:0];
				end
				fwm_pkg::REG_DIST_LIMIT: begin
					dist_limit_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Reference lanes: target, then variants
	always_comb begin
		for (int l = 0; l < NREF; l++) begin
			case (l)
				0: begin
					ref_word[l] = target_word_q;
					ref_len[l]  = target_len_q;
				end
				1: begin
					ref_word[l] = variant_a_word_q;
					ref_len[l]  = variant_a_len_q;
				end
				default: begin
					ref_word[l] = variant_b_word_q;
					ref_len[l]  = variant_b_len_q;
				end
			endcase
			lane_on[l] = (l == 0) || (int'(nv) >= l);
		end
	end

	// Exact compare and approximate eligibility per lane
	always_comb begin
		logic eq;
		for (int l = 0; l < NREF; l++) begin
			eq = (ref_len[l] == in_len);
			for (int b = 0; b < LEN_CAP; b++) begin
				if ((LEN_W'(b) < in_len) &&
				    (ref_word[l][8*b +: 8] != candidate_word[8*b +: 8])) eq = 1'b0;
			end
			exact_lane[l] = lane_on[l] && eq;
			elig_lane[l]  = lane_on[l] && (in_len != '0) && (ref_len[l] != '0) &&
			                (ref_word[l][7:0] == candidate_word[7:0]);
		end
	end

	// Row source feeding the first cell
	assign feed = (state_q == S_RUN) && (row_q <= ROW_W'(xlen_q));
	assign lnk[0].vld  = feed;
	assign lnk[0].last = (row_q == ROW_W'(xlen_q));
	assign lnk[0].chr  = cand_q[7:0];
	for (genvar l = 0; l < NREF; l++) begin : g_row_src
		assign left_v[0][l] = DIST_W'(row_q);
		assign diag_v[0][l] = DIST_W'(row_q - ROW_W'(1));
	end

	// Chain of column cells
	for (genvar j = 0; j < LEN_CAP; j++) begin : g_col
		logic [NREF-1:0][7:0] chr;
		for (genvar l = 0; l < NREF; l++) begin : g_lane
			assign chr[l] = ref_word[l][8*j +: 8];
		end
		fwm_cell #(
			.NREF  (NREF),
			.DIST_W(DIST_W),
			.COL   (j + 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.init   (accept),
			.ref_chr(chr),
			.link_i (lnk[j]),
			.left_i (left_v[j]),
			.diag_i (diag_v[j]),
			.link_o (lnk[j+1]),
			.left_o (left_v[j+1]),
			.diag_o (diag_v[j+1])
		);
		assign last_vec[j] = lnk[j+1].vld && lnk[j+1].last;
	end

	// Pick up the final distance at the column matching each lane's length
	always_comb begin
		cap_en = '0;
		cap_d  = '0;
		for (int j = 0; j < LEN_CAP; j++) begin
			for (int l = 0; l < NREF; l++) begin
				if (last_vec[j] && (ref_len[l] == LEN_W'(j + 1))) begin
					cap_en[l] = 1'b1;
					cap_d[l]  = left_v[j+1][l];
				end
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						cnt_q   <= '0;
						row_q   <= ROW_W'(1);
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (feed) row_q <= row_q + ROW_W'(1);
					if (cnt_q == LAST_CNT) state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q  <= candidate_word[CAND_W-1:0];
			xlen_q  <= in_len;
			exact_q <= |exact_lane;
			elig_q  <= elig_lane;
			hit_q   <= '0;
		end else begin
			if (feed) cand_q <= cand_q >> 8;
			for (int l = 0; l < NREF; l++) begin
				if (cap_en[l]) hit_q[l] <= (4'(cap_d[l]) <= dist_limit_q);
			end
		end
	end

	// Result
	assign done = (state_q == S_DONE);
	assign match_kind = exact_q             ? fwm_pkg::KIND_EXACT  :
	                    (|(elig_q & hit_q)) ? fwm_pkg::KIND_APPROX :
	                                          fwm_pkg::KIND_NONE;

	// Checks
	`FWM_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy not raised after accept")
	`FWM_ASSERT_SAME(a_fixed_latency, accept, ##LATENCY done, "result strobe late or missing")
	`FWM_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe longer than one cycle")
	`FWM_ASSERT_SAME(a_one_last_row, 1'b1, $onehot0(last_vec), "last row in two cells")

endmodule

// ----- tb/sv/fuzzy_word_matcher_unit_tb.sv -----
// Self-checking testbench for fuzzy_word_matcher_unit: predicts match_kind for every word.
// Needs fwm_pkg and the fuzzy_word_matcher_unit RTL; reads no files.
module fuzzy_word_matcher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         WORD_BYTES     = 8;
	localparam int         RAND_PHASES    = 11;
	localparam int         WORDS_PER_PASS = 107;
	localparam int         SETTLE_CYCLES  = 24;     // wait after the last result before the next config
	localparam logic [3:0] REG_SPARE_FIRST = 4'd8;  // indexes past the map, dropped by the block
	localparam logic [3:0] REG_SPARE_LAST  = 4'd15;
	localparam logic [7:0] CHR_BASE       = 8'h41;

	typedef enum int {EDIT_SUB, EDIT_INS, EDIT_DEL} edit_op_t;

	// Predicts the match kind of each accepted word and checks results in order
	class match_board;
		logic [63:0] ref_word [3];   // target, variant a, variant b
		int          ref_len [3];
		int          var_count;
		int          dist_limit;
		logic [1:0]  expected_kinds [$];
		int          errors;

		function new();
			for (int k = 0; k < 3; k++) begin
				ref_word[k] = '0;
				ref_len[k]  = 0;
			end
			var_count  = 0;
			dist_limit = int'(fwm_pkg::MAX_DIST_RESET);
			errors     = 0;
		endfunction

		function int cap_len(logic [3:0] v);
			return (v > WORD_BYTES) ? WORD_BYTES : int'(v);
		endfunction

		function void set_reg(logic [3:0] idx, logic [63:0] d);
			case (idx)
				fwm_pkg::REG_TARGET_WORD:    ref_word[0] = d;
				fwm_pkg::REG_TARGET_LEN:     ref_len[0]  = cap_len(d[3:0]);
				fwm_pkg::REG_VARIANT_A_WORD: ref_word[1] = d;
				fwm_pkg::REG_VARIANT_A_LEN:  ref_len[1]  = cap_len(d[3:0]);
				fwm_pkg::REG_VARIANT_B_WORD: ref_word[2] = d;
				fwm_pkg::REG_VARIANT_B_LEN:  ref_len[2]  = cap_len(d[3:0]);
				fwm_pkg::REG_VARIANT_COUNT:  var_count   = int'(d[1:0]);
				fwm_pkg::REG_DIST_LIMIT:     dist_limit  = int'(d[3:0]);
				default: ;
			endcase
		endfunction

		// Levenshtein distance, one DP row at a time
		function int edit_dist(logic [63:0] a, int na, logic [63:0] b, int nb);
			int prev [9];
			int cur [9];
			int best;
			for (int j = 0; j <= nb; j++) prev[j] = j;
			for (int i = 1; i <= na; i++) begin
				cur[0] = i;
				for (int j = 1; j <= nb; j++) begin
					best = prev[j-1] + int'(a[8*(i-1) +: 8] != b[8*(j-1) +: 8]);
					if (prev[j] + 1 < best) best = prev[j] + 1;
					if (cur[j-1] + 1 < best) best = cur[j-1] + 1;
					cur[j] = best;
				end
				prev = cur;
			end
			return prev[nb];
		endfunction

		function logic [1:0] predict_kind(logic [63:0] w, logic [3:0] l);
			int n;
			int refs;
			bit hit;
			n    = cap_len(l);
			refs = 1 + ((var_count > 2) ? 2 : var_count);
			// exact match wins over any approximate one
			for (int k = 0; k < refs; k++) begin
				hit = (n == ref_len[k]);
				for (int i = 0; i < n; i++)
					if (w[8*i +: 8] != ref_word[k][8*i +: 8]) hit = 0;
				if (hit) return fwm_pkg::KIND_EXACT;
			end
			for (int k = 0; k < refs; k++)
				if (n != 0 && ref_len[k] != 0 && w[7:0] == ref_word[k][7:0] &&
				    edit_dist(w, n, ref_word[k], ref_len[k]) <= dist_limit)
					return fwm_pkg::KIND_APPROX;
			return fwm_pkg::KIND_NONE;
		endfunction

		function void note_word(logic [63:0] w, logic [3:0] l);
			expected_kinds.insert(expected_kinds.size(), predict_kind(w, l));
		endfunction

		function void check_kind(logic [1:0] got);
			logic [1:0] want;
			if (expected_kinds.size() == 0) begin
				$error("match_kind: got %0d with no word pending", got);
				errors++;
				return;
			end
			want = expected_kinds.pop_front();
			if (got !== want) begin
				$error("match_kind: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_kinds.size();
		endfunction
	endclass

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        start          = 1'b0;
	logic        busy;
	logic [63:0] candidate_word = '0;
	logic [3:0]  candidate_len  = '0;
	logic        done;
	logic [1:0]  match_kind;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index      = '0;
	logic [63:0] cfg_data       = '0;

	match_board  board;
	bit          idle_on;
	logic [63:0] gen_word [3];   // current target and variants, for candidate generation
	int          gen_len [3];

	fuzzy_word_matcher_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.candidate_word (candidate_word),
		.candidate_len  (candidate_len),
		.done           (done),
		.match_kind     (match_kind),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Result monitor: done is a one-cycle strobe
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) board.check_kind(match_kind);
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Word generation helpers
	function automatic logic [63:0] pack(string s);
		logic [63:0] w;
		w = '0;
		for (int i = 0; i < s.len() && i < WORD_BYTES; i++) w[8*i +: 8] = s[i];
		return w;
	endfunction

	function automatic logic [7:0] rand_chr();
		if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
		return CHR_BASE + 8'($urandom_range(0, 3));
	endfunction

	// Full word of random characters, mostly from the small alphabet
	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		for (int i = 0; i < WORD_BYTES; i++) w[8*i +: 8] = rand_chr();
		return w;
	endfunction

	function automatic int rand_len();
		if ($urandom_range(0, 15) == 0) return 0;
		return $urandom_range(1, WORD_BYTES);
	endfunction

	// full-length words sometimes carry an oversize length code
	function automatic logic [3:0] raw_len(int n);
		if (n == WORD_BYTES && $urandom_range(0, 2) == 0) return 4'($urandom_range(8, 15));
		return 4'(n);
	endfunction

	// Applies random edits; bytes past the length become junk
	function automatic logic [63:0] mutate(input logic [63:0] w, inout int n, input int edits);
		logic [7:0]  b [8];
		logic [63:0] res;
		int          pos;
		for (int i = 0; i < 8; i++) b[i] = w[8*i +: 8];
		if (n > WORD_BYTES) n = WORD_BYTES;
		repeat (edits) begin
			case (edit_op_t'($urandom_range(0, 2)))
				EDIT_SUB: if (n > 0) b[$urandom_range(0, n - 1)] = rand_chr();
				EDIT_INS: if (n < WORD_BYTES) begin
					pos = $urandom_range(0, n);
					for (int i = 7; i > pos; i--) b[i] = b[i-1];
					b[pos] = rand_chr();
					n++;
				end
				default: if (n > 0) begin
					pos = $urandom_range(0, n - 1);
					for (int i = pos; i < 7; i++) b[i] = b[i+1];
					n--;
				end
			endcase
		end
		for (int i = 0; i < 8; i++) res[8*i +: 8] = (i < n) ? b[i] : 8'($urandom_range(0, 255));
		return res;
	endfunction

	// Upper bits the register does not hold are sometimes set at random
	function automatic logic [63:0] with_noise(logic [63:0] v, logic [63:0] keep);
		if ($urandom_range(0, 1) == 0) return v;
		return ({$urandom(), $urandom()} & ~keep) | v;
	endfunction

	// Config channel: valid stays high across a burst of writes
	task automatic write_reg(input logic [3:0] idx, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.set_reg(idx, d);
	endtask

	task automatic load_config(input logic [63:0] tw, input logic [3:0] tl,
			input logic [63:0] aw, input logic [3:0] al,
			input logic [63:0] bw, input logic [3:0] bl,
			input logic [1:0] cnt, input logic [3:0] md);
		write_reg(fwm_pkg::REG_TARGET_WORD, tw);
		write_reg(fwm_pkg::REG_TARGET_LEN, with_noise(64'(tl), 64'hF));
		write_reg(fwm_pkg::REG_VARIANT_A_WORD, aw);
		write_reg(fwm_pkg::REG_VARIANT_A_LEN, with_noise(64'(al), 64'hF));
		write_reg(fwm_pkg::REG_VARIANT_B_WORD, bw);
		write_reg(fwm_pkg::REG_VARIANT_B_LEN, with_noise(64'(bl), 64'hF));
		write_reg(fwm_pkg::REG_VARIANT_COUNT, with_noise(64'(cnt), 64'h3));
		write_reg(fwm_pkg::REG_DIST_LIMIT, with_noise(64'(md), 64'hF));
		if ($urandom_range(0, 1) == 0)
			write_reg(4'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
				{$urandom(), $urandom()});
		cfg_valid <= 1'b0;
	endtask

	// One command transaction; start stays high when the next word follows at once
	task automatic issue_word(input logic [63:0] w, input logic [3:0] l);
		start          <= 1'b1;
		candidate_word <= w;
		candidate_len  <= l;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_word(w, l);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Block is idle once every result is in and busy is low
	task automatic drain_results();
		start <= 1'b0;
		while (board.pending() != 0 || busy !== 1'b0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [63:0] w;
		logic [3:0]  lens [3];
		int          n;
		int          sel;
		int          r;
		logic [3:0]  md;

		board = new();
		idle_on = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed: target with two near spellings, limit 2
		load_config(pack("ROVER"), 4'd5, pack("ROVR"), 4'd4, pack("ROUVER"), 4'd6, 2'd2, 4'd2);
		issue_word(pack("ROVER"), 4'd5);
		issue_word(pack("ROVR"), 4'd4);
		issue_word(pack("ROUVER"), 4'd6);
		issue_word(pack("ROBER"), 4'd5);
		issue_word(pack("XOVER"), 4'd5);        // first byte differs
		issue_word(pack("RZZZZ"), 4'd5);        // too far from all
		issue_word(pack("ROVER"), 4'd0);        // empty candidate
		issue_word(pack("rover"), 4'd5);        // case matters
		issue_word(pack("ROVER") | 64'hA5C3_7E00_0000_0000, 4'd5);  // junk past length
		issue_word(pack("ROVERSXY"), 4'd15);    // length saturates
		issue_word('1, 4'd8);
		issue_word('0, 4'd8);
		drain_results();

		// Directed: empty target, oversize lengths, variant count and limit
		load_config('1, 4'd0, '1, 4'd8, pack("ABCDEFGH"), 4'd15, 2'd3, 4'd15);
		issue_word('0, 4'd0);                   // empty matches empty target
		issue_word(64'hFF, 4'd1);
		issue_word(pack("ABCDEFGH"), 4'd12);
		issue_word(pack("AXXXXXXX"), 4'd8);
		issue_word('0, 4'd8);
		drain_results();

		// Directed: zero limit, no variants in use
		load_config(pack("SAT"), 4'd3, pack("SATS"), 4'd4, pack("STA"), 4'd3, 2'd0, 4'd0);
		issue_word(pack("SATS"), 4'd4);
		issue_word(pack("SAT"), 4'd3);
		issue_word(pack("SAX"), 4'd3);
		drain_results();
		load_config(pack("SAT"), 4'd3, pack("SATS"), 4'd4, pack("STA"), 4'd3, 2'd1, 4'd8);
		issue_word(pack("SATS"), 4'd4);
		issue_word(pack("STA"), 4'd3);          // variant b not in use
		issue_word(pack("SQQQQQQQ"), 4'd8);
		drain_results();

		// Random passes: variants derived from the target, candidates mostly near them
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			idle_on = (ph < RAND_PHASES - 1);
			gen_len[0]  = rand_len();
			gen_word[0] = mutate(rand_word(), gen_len[0], 0);
			for (int k = 0; k < 3; k++) begin
				if (k > 0) begin
					n = gen_len[0];
					if ($urandom_range(0, 5) == 0) n = rand_len();
					gen_word[k] = mutate(gen_word[0], n, (n == gen_len[0]) ? $urandom_range(0, 3) : 8);
					gen_len[k]  = n;
				end
				lens[k] = raw_len(gen_len[k]);
			end
			r = $urandom_range(0, 7);
			md = (r < 6) ? 4'($urandom_range(0, 3)) :
				(r == 6) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(9, 15));
			load_config(gen_word[0], lens[0], gen_word[1], lens[1], gen_word[2], lens[2],
				2'($urandom_range(0, 3)), md);

			for (int i = 0; i < WORDS_PER_PASS; i++) begin
				sel = $urandom_range(0, 2);
				r   = $urandom_range(0, 9);
				n   = gen_len[sel];
				if (r < 3) begin
					w = mutate(gen_word[sel], n, 0);
				end else if (r < 8) begin
					w = mutate(gen_word[sel], n, $urandom_range(1, 3));
				end else if (r == 8) begin
					n = rand_len();
					w = mutate({$urandom(), $urandom()}, n, 0);
				end else begin
					w = {$urandom(), $urandom()};
					n = -1;
				end
				issue_word(w, (n < 0) ? 4'($urandom_range(0, 15)) : raw_len(n));
			end
			drain_results();
		end

		if (board.errors == 0 && board.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
